>>> src/rripdb_pkg.sv
// Shared types and constants for the RRIP replacement controller.
// Used by rripdb_ctrl, rripdb_dp and the top level.
`timescale 1ns / 1ps

package rripdb_pkg;

	localparam int CMD_W     = 2;
	localparam int SET_IN_W  = 11;
	localparam int WAY_IN_W  = 5;
	localparam int CORE_ID_W = 2;
	localparam int VICTIM_W  = 4;
	localparam int OWN_W     = 2;
	localparam int CNT_W     = 16;
	localparam int THR_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	localparam logic [CNT_W-1:0] CNT_MAX       = '1;
	localparam logic [THR_W-1:0] PCT_SCALE     = 7'd100;
	localparam logic [CNT_W-1:0] PHASE_LEN_RST = 16'd1024;
	localparam logic [THR_W-1:0] DEAD_THR_RST  = 7'd50;

	localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd0;
	localparam logic [CMD_W-1:0] CMD_HIT    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MISS   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_FILL   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_LEN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_THR  = 1'd1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_MUL,
		S_PHASE,
		S_COMMIT
	} state_t;

	typedef struct packed {
		logic accept;  // latch item, read set row
		logic clr;     // write one reset row of the sweep
		logic count;   // update dead / insertion counters
		logic mul;     // register phase products
		logic phase;   // set mode, halve counters
		logic commit;  // write row back, load result
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic close;
		logic out_free;
	} dp_status_t;

endpackage

>>> src/rripdb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rripdb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/rripdb_ctrl.sv
// Sequencer for the replacement controller: clearing sweep, accept,
// execute, phase close and commit. Uses rripdb_pkg.
`timescale 1ns / 1ps

module rripdb_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  rripdb_pkg::dp_status_t status,
	output rripdb_pkg::ctrl_cmd_t  ctl
);

	import rripdb_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				ctl.clr = 1'b1;
				if (status.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				// phase close takes the long path; counters move only once
				if (status.close) begin
					ctl.count = 1'b1;
					state_d   = S_MUL;
				end else if (status.out_free) begin
					ctl.count  = 1'b1;
					ctl.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_MUL: begin
				ctl.mul = 1'b1;
				state_d = S_PHASE;
			end
			S_PHASE: begin
				ctl.phase = 1'b1;
				state_d   = S_COMMIT;
			end
			S_COMMIT: begin
				if (status.out_free) begin
					ctl.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

>>> src/rripdb_dp.sv
// Datapath: set-row RAM, victim search and aging, per-core phase counters,
// configuration registers and the result register. Uses rripdb_pkg, rripdb_ram.
`timescale 1ns / 1ps

module rripdb_dp #(
	parameter int NUM_SETS  = 2048,
	parameter int NUM_WAYS  = 16,
	parameter int NUM_CORES = 4,
	parameter int RRPV_MAX  = 3
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rripdb_pkg::ctrl_cmd_t                 ctl,
	output rripdb_pkg::dp_status_t                status,
	input  logic [rripdb_pkg::CMD_W-1:0]          cmd,
	input  logic [rripdb_pkg::SET_IN_W-1:0]       set_index,
	input  logic [rripdb_pkg::WAY_IN_W-1:0]       way_index,
	input  logic [rripdb_pkg::CORE_ID_W-1:0]      core_id,
	input  logic                                  victim_valid,
	input  logic                                  cfg_valid,
	input  logic [rripdb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rripdb_pkg::CFG_DAT_W-1:0]      cfg_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [rripdb_pkg::VICTIM_W-1:0]       victim_way,
	output logic                                  core_mode
);

	import rripdb_pkg::*;

	localparam int RV_W  = $clog2(RRPV_MAX + 1);
	localparam int WAY_W = $clog2(NUM_WAYS);
	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int ROW_W = NUM_WAYS * (RV_W + 1 + OWN_W);
	localparam int REU_O = NUM_WAYS * RV_W;
	localparam int OWN_O = NUM_WAYS * (RV_W + 1);
	localparam int PD_W  = CNT_W + THR_W;
	localparam int PI_W  = CNT_W + THR_W + 1;
	localparam logic [RV_W-1:0] RV_MAX  = RV_W'(RRPV_MAX);
	localparam logic [RV_W-1:0] RV_NEAR = RV_W'(RRPV_MAX - 1);

	// item registers
	logic [CMD_W-1:0]     cmd_q;
	logic [SET_IN_W-1:0]  set_q;
	logic [WAY_IN_W-1:0]  way_q;
	logic [CORE_ID_W-1:0] core_q;
	logic                 vv_q;

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q  <= cmd;
			set_q  <= set_index;
			way_q  <= way_index;
			core_q <= core_id;
			vv_q   <= victim_valid;
		end
	end

	// configuration
	logic [CNT_W-1:0] phase_len_q;
	logic [THR_W-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_len_q <= PHASE_LEN_RST;
			thr_q       <= DEAD_THR_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_PHASE_LEN) begin
				phase_len_q <= cfg_data[CNT_W-1:0];
			end else if (cfg_index == REG_DEAD_THR) begin
				thr_q <= cfg_data[THR_W-1:0];
			end
		end
	end

	// clearing sweep
	logic [SET_W-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (ctl.clr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// set-row memory
	logic             ram_we;
	logic [SET_W-1:0] ram_waddr;
	logic [ROW_W-1:0] ram_wdata;
	logic [ROW_W-1:0] ram_rdata;
	logic [ROW_W-1:0] row_new;
	logic [ROW_W-1:0] row_rst;
	logic             set_ok;

	rripdb_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_SETS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ctl.accept),
		.raddr(SET_W'(set_index)),
		.rdata(ram_rdata)
	);

	assign ram_we    = ctl.clr || (ctl.commit && set_ok);
	assign ram_waddr = ctl.clr ? clr_cnt_q : SET_W'(set_q);
	assign ram_wdata = ctl.clr ? row_rst : row_new;

	// decode
	logic way_ok, core_ok, is_fill;

	assign set_ok  = 32'(set_q) < NUM_SETS;
	assign way_ok  = 32'(way_q) < NUM_WAYS;
	assign core_ok = 32'(core_q) < NUM_CORES;
	assign is_fill = (cmd_q == CMD_FILL) && set_ok;

	// row unpack
	logic [RV_W-1:0]  rv_cur  [NUM_WAYS];
	logic             reu_cur [NUM_WAYS];
	logic [OWN_W-1:0] own_cur [NUM_WAYS];
	logic             sel_reuse;
	logic [OWN_W-1:0] sel_own;

	always_comb begin
		sel_reuse = 1'b0;
		sel_own   = '0;
		row_rst   = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			rv_cur[w]  = ram_rdata[w*RV_W +: RV_W];
			reu_cur[w] = ram_rdata[REU_O + w];
			own_cur[w] = ram_rdata[OWN_O + w*OWN_W +: OWN_W];
			row_rst[w*RV_W +: RV_W] = RV_MAX;
			if (32'(way_q) == w) begin
				sel_reuse = reu_cur[w];
				sel_own   = own_cur[w];
			end
		end
	end

	// victim search: highest level present, then first way at that level
	logic [RRPV_MAX:0] lvl_hit;
	logic [RV_W-1:0]   top;
	logic [RV_W-1:0]   age;
	logic [WAY_W-1:0]  victim;
	logic [31:0]       victim_ext;

	always_comb begin
		lvl_hit = '0;
		top     = '0;
		victim  = '0;
		for (int v = 0; v <= RRPV_MAX; v++) begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				if (rv_cur[w] == RV_W'(v)) begin
					lvl_hit[v] = 1'b1;
				end
			end
			if (lvl_hit[v]) begin
				top = RV_W'(v);
			end
		end
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (rv_cur[w] == top) begin
				victim = WAY_W'(w);
			end
		end
		age        = RV_MAX - top;
		victim_ext = 32'(victim);
	end

	// per-core counters
	logic [CNT_W-1:0] ins_q  [NUM_CORES];
	logic [CNT_W-1:0] dead_q [NUM_CORES];
	logic             mode_q [NUM_CORES];
	logic [CNT_W-1:0] ins_sel, dead_sel, ins_next;
	logic             mode_sel;
	logic             dead_inc, ins_inc;

	always_comb begin
		ins_sel  = '0;
		dead_sel = '0;
		mode_sel = mode_q[0];
		for (int c = 0; c < NUM_CORES; c++) begin
			if (32'(core_q) == c) begin
				ins_sel  = ins_q[c];
				dead_sel = dead_q[c];
				mode_sel = mode_q[c];
			end
		end
		ins_next = (ins_sel == CNT_MAX) ? ins_sel : ins_sel + 1'b1;
		dead_inc = is_fill && way_ok && vv_q && !sel_reuse && (32'(sel_own) < NUM_CORES);
		ins_inc  = is_fill && core_ok;
	end

	// phase close compares dead*100 >= (thr+1)*ins, same as pct > thr
	logic [PD_W-1:0] prod_dead_q;
	logic [PI_W-1:0] prod_ins_q;
	logic            distant;

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_dead_q <= PD_W'(dead_sel) * PD_W'(PCT_SCALE);
			prod_ins_q  <= PI_W'(ins_sel) * PI_W'({1'b0, thr_q} + 8'd1);
		end
	end

	assign distant = PI_W'(prod_dead_q) >= prod_ins_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CORES; c++) begin
				ins_q[c]  <= '0;
				dead_q[c] <= '0;
				mode_q[c] <= 1'b0;
			end
		end else begin
			for (int c = 0; c < NUM_CORES; c++) begin
				if (ctl.count) begin
					if (dead_inc && 32'(sel_own) == c && dead_q[c] != CNT_MAX) begin
						dead_q[c] <= dead_q[c] + 1'b1;
					end
					if (ins_inc && 32'(core_q) == c) begin
						ins_q[c] <= ins_next;
					end
				end
				if (ctl.phase && 32'(core_q) == c) begin
					mode_q[c] <= distant;
					ins_q[c]  <= ins_q[c] >> 1;
					dead_q[c] <= dead_q[c] >> 1;
				end
			end
		end
	end

	// row update
	always_comb begin
		row_new = ram_rdata;
		for (int w = 0; w < NUM_WAYS; w++) begin
			case (cmd_q)
				CMD_VICTIM: begin
					row_new[w*RV_W +: RV_W] = rv_cur[w] + age;
				end
				CMD_HIT: begin
					if (32'(way_q) == w) begin
						row_new[w*RV_W +: RV_W] = '0;
						row_new[REU_O + w]      = 1'b1;
					end
				end
				CMD_MISS: begin
					if (32'(way_q) == w) begin
						row_new[w*RV_W +: RV_W] = RV_MAX;
					end
				end
				CMD_FILL: begin
					if (32'(way_q) == w) begin
						row_new[w*RV_W +: RV_W]          = mode_sel ? RV_MAX : RV_NEAR;
						row_new[REU_O + w]               = 1'b0;
						row_new[OWN_O + w*OWN_W +: OWN_W] = OWN_W'(core_q);
					end
				end
				default: begin
					row_new = ram_rdata;
				end
			endcase
		end
	end

	// result register
	logic                out_valid_q;
	logic [VICTIM_W-1:0] victim_way_q;
	logic                core_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			victim_way_q <= (cmd_q == CMD_VICTIM && set_ok) ? victim_ext[VICTIM_W-1:0] : '0;
			core_mode_q  <= mode_sel;
		end
	end

	assign out_valid  = out_valid_q;
	assign victim_way = victim_way_q;
	assign core_mode  = core_mode_q;

	assign status.clr_last = 32'(clr_cnt_q) == NUM_SETS - 1;
	assign status.close    = ins_inc && (ins_next >= phase_len_q);
	assign status.out_free = !out_valid_q || out_ready;

endmodule

>>> src/rrip_deadblock_adaptive_insertion.sv
// Top level of the RRIP replacement controller with dead-block-aware insertion.
// Instantiates rripdb_ctrl and rripdb_dp; uses rripdb_pkg.
//
//  channel  signals                                          direction
//  in       in_valid/in_ready, cmd, set_index, way_index,    to block
//           core_id, victim_valid
//  out      out_valid/out_ready, victim_way, core_mode       from block
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data         to block
//
// An item passes through accept, with the set-row read, then execute and write back.
// A fill that closes a phase goes on from execute through S_MUL, which loads the two
// product registers, S_PHASE (compare, counter halving) and S_COMMIT (write-back).
// After reset a clearing pass writes every set row, with in_ready low throughout;
// cfg writes are taken throughout (cfg_ready is always high).
// A result waiting in the output register lets the next item in, which then holds
// in execute (in commit, for a fill that closes a phase) until out_ready.
`timescale 1ns / 1ps

module rrip_deadblock_adaptive_insertion #(
	parameter int NUM_SETS  = 2048,
	parameter int NUM_WAYS  = 16,
	parameter int NUM_CORES = 4,
	parameter int RRPV_MAX  = 3
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [rripdb_pkg::CMD_W-1:0]     cmd,
	input  logic [rripdb_pkg::SET_IN_W-1:0]  set_index,
	input  logic [rripdb_pkg::WAY_IN_W-1:0]  way_index,
	input  logic [rripdb_pkg::CORE_ID_W-1:0] core_id,
	input  logic                             victim_valid,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [rripdb_pkg::VICTIM_W-1:0]  victim_way,
	output logic                             core_mode,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rripdb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rripdb_pkg::CFG_DAT_W-1:0] cfg_data
);

	import rripdb_pkg::*;

	ctrl_cmd_t  ctl;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	rripdb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.ctl     (ctl)
	);

	rripdb_dp #(
		.NUM_SETS (NUM_SETS),
		.NUM_WAYS (NUM_WAYS),
		.NUM_CORES(NUM_CORES),
		.RRPV_MAX (RRPV_MAX)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.status      (status),
		.cmd         (cmd),
		.set_index   (set_index),
		.way_index   (way_index),
		.core_id     (core_id),
		.victim_valid(victim_valid),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.victim_way  (victim_way),
		.core_mode   (core_mode)
	);

endmodule

>>> test/rrip_deadblock_adaptive_insertion_tb.sv
`timescale 1ns / 1ps
// Testbench for rrip_deadblock_adaptive_insertion: directed and random accesses,
// each result checked against an in-bench copy of the replacement and phase state.
// Depends on rripdb_pkg and the block's RTL.

module rrip_deadblock_adaptive_insertion_tb;
	import rripdb_pkg::*;

	localparam int NUM_SETS    = 2048;
	localparam int NUM_WAYS    = 16;
	localparam int NUM_CORES   = 4;
	localparam int RRPV_MAX    = 3;
	localparam int SLOTS       = NUM_SETS * NUM_WAYS;
	localparam int STALL_LIMIT = 20000;
	localparam int LONG_HOLD   = 300;
	localparam int HOLD_AT     = 500;

	typedef struct packed {
		logic [CMD_W-1:0]     cmd;
		logic [SET_IN_W-1:0]  set_idx;
		logic [WAY_IN_W-1:0]  way;
		logic [CORE_ID_W-1:0] core;
		logic                 vvalid;
	} access_t;

	typedef struct packed {
		logic [VICTIM_W-1:0] victim;
		logic                mode;
	} result_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic [CMD_W-1:0]     cmd          = '0;
	logic [SET_IN_W-1:0]  set_index    = '0;
	logic [WAY_IN_W-1:0]  way_index    = '0;
	logic [CORE_ID_W-1:0] core_id      = '0;
	logic                 victim_valid = 1'b0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic [VICTIM_W-1:0]  victim_way;
	logic                 core_mode;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_DAT_W-1:0] cfg_data     = '0;

	rrip_deadblock_adaptive_insertion #(
		.NUM_SETS(NUM_SETS),
		.NUM_WAYS(NUM_WAYS),
		.NUM_CORES(NUM_CORES),
		.RRPV_MAX(RRPV_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.set_index(set_index),
		.way_index(way_index),
		.core_id(core_id),
		.victim_valid(victim_valid),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.victim_way(victim_way),
		.core_mode(core_mode),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the replacement state
	logic [1:0]       rrpv_m      [SLOTS];
	bit               reuse_m     [SLOTS];
	logic [OWN_W-1:0] owner_m     [SLOTS];
	bit               slot_filled [SLOTS];
	int unsigned      ins_m       [NUM_CORES];
	int unsigned      dead_m      [NUM_CORES];
	bit               mode_m      [NUM_CORES];
	int unsigned      phase_len_m;
	int unsigned      thr_m;

	access_t access_q[$];
	result_t victim_mode_q[$];
	int      issued       = 0;
	int      results_seen = 0;
	int      err_cnt      = 0;

	// At this size every set index and core id is in range, and owners are 2-bit cores.
	function automatic result_t replacement_update(access_t a);
		result_t     r;
		int unsigned base, w, best, top, diff, own, pct, c;
		bit          bypass;
		r = '0;
		c = 32'(a.core);
		base = 32'(a.set_idx) * NUM_WAYS;
		case (a.cmd)
			CMD_VICTIM: begin
				best = 0;
				top = 32'(rrpv_m[base]);
				for (w = 1; w < NUM_WAYS; w++) begin
					if (32'(rrpv_m[base + w]) > top) begin
						top = 32'(rrpv_m[base + w]);
						best = w;
					end
				end
				// age the whole set so the chosen way reaches the maximum
				if (top < RRPV_MAX) begin
					diff = RRPV_MAX - top;
					for (w = 0; w < NUM_WAYS; w++)
						rrpv_m[base + w] = 2'(32'(rrpv_m[base + w]) + diff);
				end
				r.victim = VICTIM_W'(best);
			end
			CMD_HIT: begin
				if (a.way < NUM_WAYS) begin
					rrpv_m[base + a.way] = '0;
					reuse_m[base + a.way] = 1'b1;
				end
			end
			CMD_MISS: begin
				if (a.way < NUM_WAYS)
					rrpv_m[base + a.way] = 2'(RRPV_MAX);
			end
			default: begin
				bypass = a.way >= NUM_WAYS;
				if (!bypass && a.vvalid) begin
					own = 32'(owner_m[base + a.way]);
					if (!reuse_m[base + a.way] && dead_m[own] < CNT_MAX)
						dead_m[own]++;
				end
				if (ins_m[c] < CNT_MAX)
					ins_m[c]++;
				if (ins_m[c] >= phase_len_m) begin
					pct = (dead_m[c] * PCT_SCALE) / ins_m[c];
					mode_m[c] = pct > thr_m;
					ins_m[c] = ins_m[c] / 2;
					dead_m[c] = dead_m[c] / 2;
				end
				if (!bypass) begin
					rrpv_m[base + a.way] = 2'(mode_m[c] ? RRPV_MAX : RRPV_MAX - 1);
					reuse_m[base + a.way] = 1'b0;
					owner_m[base + a.way] = a.core;
				end
			end
		endcase
		r.mode = mode_m[c];
		return r;
	endfunction

	// driver
	int src_gap   = 0;
	bit src_burst = 1'b0;

	always @(posedge clk or negedge arst_n) begin : drv
		access_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			src_gap <= 0;
			src_burst <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				victim_mode_q.push_back(replacement_update(
					{cmd, set_index, way_index, core_id, victim_valid}));
			if (in_valid && !in_ready) begin
				// item still waiting, hold payload
			end else if (src_gap != 0) begin
				src_gap <= src_gap - 1;
				in_valid <= 1'b0;
			end else if (access_q.size() != 0) begin
				nxt = access_q.pop_front();
				cmd <= nxt.cmd;
				set_index <= nxt.set_idx;
				way_index <= nxt.way;
				core_id <= nxt.core;
				victim_valid <= nxt.vvalid;
				in_valid <= 1'b1;
				if ($urandom_range(0, 39) == 0)
					src_burst <= !src_burst;
				src_gap <= src_burst ? 0 : $urandom_range(0, 11);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor and checker
	int snk_stall = 0;
	int hold_left = 0;
	bit snk_burst = 1'b0;

	always @(posedge clk or negedge arst_n) begin : mon
		result_t exp_r;
		int      n, h;
		if (!arst_n) begin
			out_ready <= 1'b0;
			snk_stall <= 0;
			hold_left <= 0;
			snk_burst <= 1'b0;
		end else begin
			n = snk_stall;
			h = hold_left;
			if (out_valid && out_ready) begin
				if (victim_mode_q.size() == 0) begin
					$error("unexpected result: victim_way %0d core_mode %0d",
						victim_way, core_mode);
					err_cnt++;
				end else begin
					exp_r = victim_mode_q.pop_front();
					if (victim_way !== exp_r.victim) begin
						$error("victim_way: expected %0d, got %0d", exp_r.victim, victim_way);
						err_cnt++;
					end
					if (core_mode !== exp_r.mode) begin
						$error("core_mode: expected %0d, got %0d", exp_r.mode, core_mode);
						err_cnt++;
					end
				end
				results_seen <= results_seen + 1;
				// one long back-pressure stretch so the input side stalls
				if (results_seen == HOLD_AT)
					h = LONG_HOLD;
				if ($urandom_range(0, 39) == 0)
					snk_burst <= !snk_burst;
				n = snk_burst ? 0 : $urandom_range(0, 11);
			end
			if (h != 0) begin
				hold_left <= h - 1;
				snk_stall <= n;
				out_ready <= 1'b0;
			end else if (n != 0) begin
				hold_left <= 0;
				snk_stall <= n - 1;
				out_ready <= 1'b0;
			end else begin
				hold_left <= 0;
				snk_stall <= 0;
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no handshake at all
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_PHASE_LEN)
			phase_len_m = 32'(val);
		else
			thr_m = 32'(val[THR_W-1:0]);
	endtask

	function automatic void queue_access(input logic [CMD_W-1:0] c, input int s, input int w,
		input int k, input bit v);
		access_t a;
		a.cmd = c;
		a.set_idx = SET_IN_W'(s);
		a.way = WAY_IN_W'(w);
		a.core = CORE_ID_W'(k);
		a.vvalid = v;
		if (c == CMD_FILL && a.way < NUM_WAYS) begin
			// a valid victim is only reported in a way that was filled before
			if (!slot_filled[a.set_idx * NUM_WAYS + a.way])
				a.vvalid = 1'b0;
			slot_filled[a.set_idx * NUM_WAYS + a.way] = 1'b1;
		end
		access_q.push_back(a);
		issued++;
	endfunction

	function automatic int pick_way();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(0, NUM_WAYS - 1);
		else if (r < 95)
			return NUM_WAYS;
		return $urandom_range(NUM_WAYS + 1, 31);
	endfunction

	// mostly a few hot sets so values age, hits land and blocks die
	task automatic random_phase(input int n);
		int s, w, k, r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 9);
			if (r < 8)
				s = $urandom_range(0, 3);
			else if (r == 8)
				s = NUM_SETS - 1;
			else
				s = $urandom_range(0, NUM_SETS - 1);
			k = $urandom_range(0, NUM_CORES - 1);
			w = pick_way();
			if ($urandom_range(0, 9) < 4) begin
				// miss sequence: find a victim, then fill the set
				queue_access(CMD_VICTIM, s, pick_way(), k, 1'($urandom_range(0, 1)));
				queue_access(CMD_FILL, s, w, k, 1'b1);
			end else begin
				queue_access(CMD_W'($urandom_range(0, 3)), s, w, k,
					1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic settle();
		while (results_seen != issued)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	int plen [8] = '{1, 32768, 4, 16, 64, 7, 1, 3};
	int thr  [8] = '{0, 100, 50, 25, 75, 100, 100, 0};

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			rrpv_m[i] = 2'(RRPV_MAX);
			reuse_m[i] = 1'b0;
			owner_m[i] = '0;
			slot_filled[i] = 1'b0;
		end
		for (int i = 0; i < NUM_CORES; i++) begin
			ins_m[i] = 0;
			dead_m[i] = 0;
			mode_m[i] = 1'b0;
		end
		phase_len_m = 32'(PHASE_LEN_RST);
		thr_m = 32'(DEAD_THR_RST);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(REG_PHASE_LEN, CFG_DAT_W'(2));
		write_reg(REG_DEAD_THR, '0);

		// directed: corners of every field and command
		queue_access(CMD_VICTIM, 0, 0, 0, 0);
		queue_access(CMD_VICTIM, NUM_SETS - 1, 31, 3, 1);
		queue_access(CMD_FILL, 0, 0, 0, 0);
		queue_access(CMD_FILL, 0, NUM_WAYS - 1, 1, 0);
		queue_access(CMD_HIT, 0, 0, 0, 0);
		queue_access(CMD_MISS, 0, NUM_WAYS - 1, 2, 1);
		queue_access(CMD_HIT, 0, NUM_WAYS, 1, 0);       // out-of-range way, ignored
		queue_access(CMD_MISS, 0, 31, 3, 1);             // out-of-range way, ignored
		queue_access(CMD_VICTIM, 0, 0, 2, 0);
		queue_access(CMD_FILL, 0, 0, 0, 1);              // reused victim, closes phase
		queue_access(CMD_FILL, 0, NUM_WAYS - 1, 1, 1);   // dead victim, closes phase
		queue_access(CMD_FILL, 5, NUM_WAYS, 2, 1);       // bypass
		queue_access(CMD_FILL, 5, 31, 3, 1);             // bypass, top way code
		queue_access(CMD_FILL, NUM_SETS - 1, 5, 3, 0);
		queue_access(CMD_FILL, NUM_SETS - 1, 5, 3, 1);
		queue_access(CMD_FILL, 0, 1, 1, 0);              // closes phase, near insertion
		queue_access(CMD_VICTIM, 0, 0, 1, 0);
		queue_access(CMD_HIT, NUM_SETS - 1, NUM_WAYS - 1, 3, 1);
		queue_access(CMD_VICTIM, NUM_SETS - 1, 0, 3, 0);
		queue_access(CMD_HIT, 0, 0, 0, 0);
		queue_access(CMD_HIT, 0, 1, 0, 0);
		queue_access(CMD_VICTIM, 0, 0, 0, 0);            // untouched ways already at the maximum, no aging
		queue_access(CMD_FILL, 0, 2, 2, 0);
		settle();

		for (int p = 0; p < 8; p++) begin
			write_reg(REG_PHASE_LEN, CFG_DAT_W'(plen[p]));
			write_reg(REG_DEAD_THR, CFG_DAT_W'(thr[p]));
			random_phase(140);
			settle();
		end

		if (err_cnt == 0 && victim_mode_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> sim.f
src/rripdb_pkg.sv
src/rripdb_ram.sv
src/rripdb_ctrl.sv
src/rripdb_dp.sv
src/rrip_deadblock_adaptive_insertion.sv
test/rrip_deadblock_adaptive_insertion_tb.sv
